/* sv/tcw_pkg.sv */
// Shared types, constants and a lookup function for the text console writer.
// Used by every module of the block but tcw_ram; depends on nothing.
package tcw_pkg;

  localparam int COLS     = 80;
  localparam int ROWS     = 25;
  localparam int CELLS    = COLS * ROWS;
  localparam int ADDR_W   = $clog2(CELLS);
  localparam int COL_W    = $clog2(COLS);
  localparam int TAB_STOP = 4;
  localparam int TAB_W    = $clog2(TAB_STOP);
  localparam int CELL_W   = 16;
  localparam int POS_W    = 11;
  localparam int IDX_W    = 11;
  localparam int QDEPTH   = 2;
  localparam int QPTR_W   = $clog2(QDEPTH);
  localparam int QCNT_W   = $clog2(QDEPTH + 1);

  localparam logic [CELL_W-1:0] BLANK_CELL = 16'h0720;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_BS    = 8'd8;
  localparam logic [7:0] CH_TAB   = 8'd9;
  localparam logic [7:0] CH_NL    = 8'd10;
  localparam logic [7:0] CH_VT    = 8'd11;
  localparam logic [7:0] CH_CR    = 8'd13;

  typedef enum logic [2:0] {
    OP_CHAR,
    OP_BS,
    OP_TAB,
    OP_NL,
    OP_VT,
    OP_CR,
    OP_READ
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [7:0]        attr;
    logic [7:0]        ch;
    logic [ADDR_W-1:0] addr;
    logic              addr_ok;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_COPY,
    ST_BLANK
  } state_t;

  function automatic logic [7:0] color_attr(input logic [2:0] idx);
    logic [7:0] a;
    case (idx)
      3'd1:    a = 8'd14;
      3'd2:    a = 8'd15;
      3'd3:    a = 8'd12;
      3'd4:    a = 8'd11;
      default: a = 8'd7;
    endcase
    return a;
  endfunction

endpackage

/* sv/tcw_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; no package needed.
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* sv/tcw_front.sv */
// Request decoder: classifies a request into a console command word.
// Depends on tcw_pkg.
module tcw_front
  import tcw_pkg::*;
(
  input  logic             req_type,
  input  logic [7:0]       char_code,
  input  logic [2:0]       color_index,
  input  logic [IDX_W-1:0] cell_index,
  output cmd_t             cmd
);

  localparam int CMP_W = ADDR_W + IDX_W + 1;

  logic [CMP_W-1:0] idx_ext;

  always_comb begin
    idx_ext     = CMP_W'(cell_index);
    cmd.attr    = color_attr(color_index);
    cmd.ch      = char_code;
    cmd.addr    = ADDR_W'(cell_index);
    cmd.addr_ok = idx_ext < CMP_W'(CELLS);
    if (req_type) begin
      cmd.op = OP_READ;
    end else begin
      case (char_code)
        CH_BS:   cmd.op = OP_BS;
        CH_TAB:  cmd.op = OP_TAB;
        CH_NL:   cmd.op = OP_NL;
        CH_VT:   cmd.op = OP_VT;
        CH_CR:   cmd.op = OP_CR;
        default: cmd.op = OP_CHAR;
      endcase
    end
  end

endmodule

/* sv/tcw_fifo.sv */
// Short command queue between the request decoder and the screen engine.
// Depends on tcw_pkg.
module tcw_fifo
  import tcw_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  cmd_t      push_cmd,
  input  logic      pop,
  output cmd_t      head,
  output q_status_t status
);

  cmd_t              slots [QDEPTH];
  logic [QPTR_W-1:0] wptr;
  logic [QPTR_W-1:0] rptr;
  logic [QCNT_W-1:0] count;

  assign head         = slots[rptr];
  assign status.full  = count == QCNT_W'(QDEPTH);
  assign status.empty = count == '0;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == QPTR_W'(QDEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == QPTR_W'(QDEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

/* sv/tcw_back.sv */
// Screen engine: runs queued commands against the cell RAM, keeps the cursor,
// scrolls, clears the screen after reset and issues one result word per command.
// Depends on tcw_pkg and tcw_ram.
module tcw_back
  import tcw_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  cmd_t              head,
  input  q_status_t         q_status,
  output logic              pop,
  output logic              clearing,
  output logic              done,
  output logic [POS_W-1:0]  cursor_pos,
  output logic [CELL_W-1:0] cell_data
);

  state_t            state;
  state_t            state_next;
  logic [ADDR_W-1:0] cnt;
  logic [ADDR_W-1:0] cursor;
  logic [ADDR_W-1:0] cursor_next;
  logic [COL_W-1:0]  col;
  logic [COL_W-1:0]  col_n;

  // datapath for a put command at the queue head
  logic [ADDR_W:0]   cur_w;
  logic [ADDR_W:0]   cur_n;
  logic [COL_W-1:0]  col_inc;
  logic [TAB_W:0]    tab_step;
  logic [COL_W:0]    col_sum;
  logic              wrap;
  logic              put_we;
  logic [ADDR_W-1:0] put_waddr;
  logic [CELL_W-1:0] put_wdata;

  // RAM and result controls
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [CELL_W-1:0] ram_wdata;
  logic [ADDR_W-1:0] ram_raddr;
  logic [CELL_W-1:0] ram_rdata;
  logic              res_fire;
  logic              res_rd;

  tcw_ram #(
    .WIDTH(CELL_W),
    .DEPTH(CELLS)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_comb begin
    cur_w     = {1'b0, cursor};
    col_inc   = (col == COL_W'(COLS - 1)) ? '0 : col + 1'b1;
    tab_step  = (TAB_W + 1)'(TAB_STOP) - {1'b0, col[TAB_W-1:0]};
    col_sum   = {1'b0, col} + (COL_W + 1)'(tab_step);
    cur_n     = cur_w;
    col_n     = col;
    put_we    = 1'b0;
    put_waddr = cursor;
    put_wdata = {head.attr, head.ch};
    case (head.op)
      OP_CHAR: begin
        put_we = 1'b1;
        cur_n  = cur_w + 1'b1;
        col_n  = col_inc;
      end
      OP_BS: begin
        // backspace at the first cell does nothing
        if (cursor != '0) begin
          put_we    = 1'b1;
          put_waddr = cursor - 1'b1;
          put_wdata = {head.attr, CH_SPACE};
          cur_n     = cur_w - 1'b1;
          col_n     = (col == '0) ? COL_W'(COLS - 1) : col - 1'b1;
        end
      end
      OP_TAB: begin
        cur_n = cur_w + (ADDR_W + 1)'(tab_step);
        col_n = (col_sum >= (COL_W + 1)'(COLS)) ? COL_W'(col_sum - (COL_W + 1)'(COLS))
                                               : COL_W'(col_sum);
      end
      OP_NL: begin
        cur_n = cur_w + (ADDR_W + 1)'(COLS) - (ADDR_W + 1)'(col);
        col_n = '0;
      end
      OP_VT: begin
        cur_n = cur_w + (ADDR_W + 1)'(COLS);
      end
      OP_CR: begin
        cur_n = cur_w - (ADDR_W + 1)'(col);
        col_n = '0;
      end
      default: begin
        cur_n = cur_w;
      end
    endcase
    wrap = cur_n >= (ADDR_W + 1)'(CELLS);
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (cnt == ADDR_W'(CELLS - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (!q_status.empty) begin
          if (head.op == OP_READ) begin
            state_next = head.addr_ok ? ST_READ : ST_IDLE;
          end else if (wrap) begin
            state_next = ST_COPY;
          end
        end
      end
      ST_READ:  state_next = ST_IDLE;
      ST_COPY: begin
        if (cnt == ADDR_W'(CELLS - COLS)) begin
          state_next = ST_BLANK;
        end
      end
      ST_BLANK: begin
        if (cnt == ADDR_W'(CELLS - 1)) begin
          state_next = ST_IDLE;
        end
      end
      default:  state_next = ST_CLEAR;
    endcase
  end

  // outputs
  always_comb begin
    pop         = 1'b0;
    ram_we      = 1'b0;
    ram_waddr   = cnt;
    ram_wdata   = BLANK_CELL;
    ram_raddr   = '0;
    res_fire    = 1'b0;
    res_rd      = 1'b0;
    cursor_next = cursor;
    clearing    = state == ST_CLEAR;
    case (state)
      ST_CLEAR: begin
        ram_we = 1'b1;
      end
      ST_IDLE: begin
        if (!q_status.empty) begin
          pop = 1'b1;
          if (head.op == OP_READ) begin
            ram_raddr = head.addr;
            res_fire  = !head.addr_ok;
          end else begin
            ram_we      = put_we;
            ram_waddr   = put_waddr;
            ram_wdata   = put_wdata;
            res_fire    = !wrap;
            cursor_next = wrap ? ADDR_W'(cur_n - (ADDR_W + 1)'(COLS)) : ADDR_W'(cur_n);
          end
        end
      end
      ST_READ: begin
        res_fire = 1'b1;
        res_rd   = 1'b1;
      end
      ST_COPY: begin
        // read one row ahead, write the word read last cycle one cell back
        if (cnt < ADDR_W'(CELLS - COLS)) begin
          ram_raddr = ADDR_W'((ADDR_W + 1)'(cnt) + (ADDR_W + 1)'(COLS));
        end
        if (cnt != '0) begin
          ram_we    = 1'b1;
          ram_waddr = cnt - 1'b1;
          ram_wdata = ram_rdata;
        end
      end
      ST_BLANK: begin
        ram_we   = 1'b1;
        res_fire = cnt == ADDR_W'(CELLS - 1);
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_CLEAR;
      cnt    <= '0;
      cursor <= '0;
      col    <= '0;
      done   <= 1'b0;
    end else begin
      state  <= state_next;
      cursor <= cursor_next;
      done   <= res_fire;
      if (pop && head.op != OP_READ) begin
        col <= col_n;
      end
      case (state)
        ST_IDLE:  cnt <= '0;
        ST_COPY:  cnt <= (cnt == ADDR_W'(CELLS - COLS)) ? cnt : cnt + 1'b1;
        default:  cnt <= cnt + 1'b1;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (res_fire) begin
      cursor_pos <= POS_W'(cursor_next);
      cell_data  <= res_rd ? ram_rdata : '0;
    end
  end

  a_no_result_while_clearing: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CLEAR) |-> !res_fire)
    else $error("result issued during screen clear");

  a_read_gives_result: assert property (@(posedge clk) disable iff (rst)
    (state == ST_READ) |=> done)
    else $error("cell read finished without a result");

  a_cursor_on_screen: assert property (@(posedge clk) disable iff (rst)
    (ADDR_W + 1)'(cursor) < (ADDR_W + 1)'(CELLS))
    else $error("cursor left the screen");

  a_pop_only_idle: assert property (@(posedge clk) disable iff (rst)
    pop |-> (state == ST_IDLE && !q_status.empty))
    else $error("command taken outside idle");

endmodule

/* sv/text_console_writer_core.sv */
// Top level of the text console writer: request decoder, command queue and
// screen engine with its cell RAM. Depends on tcw_pkg and all tcw_* modules.
//
// After reset the block holds busy high while the screen engine writes a blank
// cell into every RAM entry, one cell a cycle. A request is taken when start is
// high and busy low; up to two wait in the queue. Each request gives exactly one
// word, shown for one cycle with done high; the receiver cannot stall it. A put
// that does not scroll gives its word through the queue slot and the registered
// result outputs; a read of a cell on the screen also passes the registered RAM
// read, a read past the last cell does not. A put that runs past the last cell
// scrolls: the engine copies every cell up one row through the single RAM read
// and write port, one cell a cycle, then blanks the bottom row before it gives
// that request's word.
// Queued requests run one at a time in order behind the one in progress.
module text_console_writer_core
  import tcw_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic              req_type,
  input  logic [7:0]        char_code,
  input  logic [2:0]        color_index,
  input  logic [IDX_W-1:0]  cell_index,
  output logic              done,
  output logic [POS_W-1:0]  cursor_pos,
  output logic [CELL_W-1:0] cell_data
);

  cmd_t      dec_cmd;
  cmd_t      head;
  q_status_t q_status;
  logic      push;
  logic      pop;
  logic      clearing;

  assign busy = rst | q_status.full | clearing;
  assign push = start & ~busy;

  tcw_front u_front (
    .req_type   (req_type),
    .char_code  (char_code),
    .color_index(color_index),
    .cell_index (cell_index),
    .cmd        (dec_cmd)
  );

  tcw_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_cmd(dec_cmd),
    .pop     (pop),
    .head    (head),
    .status  (q_status)
  );

  tcw_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .q_status  (q_status),
    .pop       (pop),
    .clearing  (clearing),
    .done      (done),
    .cursor_pos(cursor_pos),
    .cell_data (cell_data)
  );

endmodule

/* sim/tcw_checker.sv */
// Checker for the text console writer: keeps its own copy of the screen and
// cursor, predicts each result word and compares it at the done strobe.
// Depends on tcw_pkg for sizes and control character codes.
`timescale 1ns / 1ps
module tcw_checker
  import tcw_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              busy,
  input  logic              req_type,
  input  logic [7:0]        char_code,
  input  logic [2:0]        color_index,
  input  logic [IDX_W-1:0]  cell_index,
  input  logic              done,
  input  logic [POS_W-1:0]  cursor_pos,
  input  logic [CELL_W-1:0] cell_data,
  output int                mismatches,
  output int                words_pending,
  output int                words_seen,
  output int                scrolls
);

  typedef struct packed {
    logic [POS_W-1:0]  pos;
    logic [CELL_W-1:0] data;
  } console_word_t;

  // Attribute per color index, index 0 in the low byte; 5..7 fall back to 7.
  localparam logic [63:0] ATTR_TABLE = {8'd7, 8'd7, 8'd7, 8'd11, 8'd12, 8'd15, 8'd14, 8'd7};

  logic [CELL_W-1:0] screen [CELLS];
  int unsigned       cur;
  console_word_t     expected_words [$];
  int                err_cnt;
  int                seen_cnt;
  int                scroll_cnt;

  task automatic note_mismatch(input string msg);
    $display("%0t ns  MISMATCH on word %0d: %s", $time, seen_cnt, msg);
    err_cnt++;
  endtask

  task automatic scroll_screen();
    for (int i = 0; i < CELLS - COLS; i++) screen[i] = screen[i + COLS];
    for (int i = CELLS - COLS; i < CELLS; i++) screen[i] = BLANK_CELL;
    scroll_cnt++;
  endtask

  task automatic console_apply(input logic rd, input logic [7:0] ch, input logic [2:0] ci,
                               input logic [IDX_W-1:0] idx, output console_word_t w);
    logic [7:0]  attr;
    int unsigned col;
    attr = ATTR_TABLE[ci*8 +: 8];
    col = cur % COLS;
    w.data = '0;
    if (rd) begin
      if (idx < CELLS) w.data = screen[idx];
    end else begin
      case (ch)
        CH_NL:  cur += COLS - col;
        CH_VT:  cur += COLS;
        CH_CR:  cur -= col;
        CH_TAB: cur += TAB_STOP - (col % TAB_STOP);
        CH_BS: begin
          // backspace at the first cell does nothing
          if (cur > 0) begin
            cur--;
            screen[cur] = {attr, CH_SPACE};
          end
        end
        default: begin
          screen[cur] = {attr, ch};
          cur++;
        end
      endcase
      if (cur >= CELLS) begin
        scroll_screen();
        cur -= COLS;
      end
    end
    w.pos = cur[POS_W-1:0];
  endtask

  always @(posedge clk) begin
    console_word_t want;
    console_word_t got;
    if (rst) begin
      for (int i = 0; i < CELLS; i++) screen[i] = BLANK_CELL;
      cur = 0;
      expected_words.delete();
    end else begin
      // retire first: a word never leaves in the cycle its request is taken
      if (done) begin
        if (expected_words.size() == 0) begin
          note_mismatch("done strobe with no request outstanding");
        end else begin
          want = expected_words.pop_front();
          seen_cnt++;
          if (cursor_pos !== want.pos)
            note_mismatch($sformatf("cursor_pos %0d, expected %0d", cursor_pos, want.pos));
          if (cell_data !== want.data)
            note_mismatch($sformatf("cell_data %h, expected %h", cell_data, want.data));
        end
      end
      if (start && !busy) begin
        console_apply(req_type, char_code, color_index, cell_index, got);
        expected_words.push_back(got);
      end
    end
    mismatches    <= err_cnt;
    words_pending <= expected_words.size();
    words_seen    <= seen_cnt;
    scrolls       <= scroll_cnt;
  end

endmodule

/* sim/tb_text_console_writer_core.sv */
// Testbench top for the text console writer: clock, reset and request
// stimulus; the verdict comes from tcw_checker. Depends on tcw_pkg.
`timescale 1ns / 1ps
module tb_text_console_writer_core;
  import tcw_pkg::*;

  logic              clk;
  logic              rst;
  logic              start;
  logic              busy;
  logic              req_type;
  logic [7:0]        char_code;
  logic [2:0]        color_index;
  logic [IDX_W-1:0]  cell_index;
  logic              done;
  logic [POS_W-1:0]  cursor_pos;
  logic [CELL_W-1:0] cell_data;

  int mismatches;
  int words_pending;
  int words_seen;
  int scrolls;
  int n_sent;
  int n_reads;

  text_console_writer_core u_dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .req_type    (req_type),
    .char_code   (char_code),
    .color_index (color_index),
    .cell_index  (cell_index),
    .done        (done),
    .cursor_pos  (cursor_pos),
    .cell_data   (cell_data)
  );

  tcw_checker u_chk (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .req_type      (req_type),
    .char_code     (char_code),
    .color_index   (color_index),
    .cell_index    (cell_index),
    .done          (done),
    .cursor_pos    (cursor_pos),
    .cell_data     (cell_data),
    .mismatches    (mismatches),
    .words_pending (words_pending),
    .words_seen    (words_seen),
    .scrolls       (scrolls)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Hold the request until the edge that takes it; leaves us on that edge.
  task automatic send_word(input logic rd, input logic [7:0] ch, input logic [2:0] ci,
                           input logic [IDX_W-1:0] idx);
    start       <= 1'b1;
    req_type    <= rd;
    char_code   <= ch;
    color_index <= ci;
    cell_index  <= idx;
    @(posedge clk);
    while (busy) @(posedge clk);
    n_sent++;
    if (rd) n_reads++;
  endtask

  task automatic maybe_idle(input int pct);
    int gap;
    if ($urandom_range(99) < pct) begin
      gap = $urandom_range(1, 6);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stop sending until every outstanding word has come back.
  task automatic drain_words();
    start <= 1'b0;
    @(posedge clk);
    while (words_pending != 0) @(posedge clk);
  endtask

  task automatic send_random();
    int               r;
    op_t              op;
    logic [7:0]       ch;
    logic [IDX_W-1:0] idx;
    r = $urandom_range(99);
    if (r < 35)      op = OP_READ;
    else if (r < 68) op = OP_CHAR;
    else if (r < 75) op = OP_BS;
    else if (r < 81) op = OP_TAB;
    else if (r < 88) op = OP_NL;
    else if (r < 92) op = OP_VT;
    else             op = OP_CR;
    case (op)
      OP_CHAR: begin
        if ($urandom_range(1)) ch = 8'($urandom_range(32, 126));
        else ch = 8'($urandom_range(255));
      end
      OP_BS:   ch = CH_BS;
      OP_TAB:  ch = CH_TAB;
      OP_NL:   ch = CH_NL;
      OP_VT:   ch = CH_VT;
      OP_CR:   ch = CH_CR;
      default: ch = 8'($urandom_range(255));
    endcase
    // reads favor the rows that writes and scrolls touch most
    r = $urandom_range(99);
    if (op != OP_READ || r < 35) idx = IDX_W'($urandom_range(2047));
    else if (r < 80)             idx = IDX_W'($urandom_range(CELLS - 4*COLS, CELLS - 1));
    else                         idx = IDX_W'($urandom_range(2*COLS - 1));
    send_word(op == OP_READ, ch, 3'($urandom_range(7)), idx);
  endtask

  initial begin
    int pct;
    rst         <= 1'b1;
    start       <= 1'b0;
    req_type    <= 1'b0;
    char_code   <= '0;
    color_index <= '0;
    cell_index  <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // blank screen, out-of-range reads, then each control code and odd bytes
    send_word(1'b1, 8'h00, 3'd0, IDX_W'(0));
    send_word(1'b1, 8'hFF, 3'd7, IDX_W'(CELLS - 1));
    send_word(1'b1, 8'h00, 3'd0, IDX_W'(CELLS));
    send_word(1'b1, 8'h00, 3'd0, IDX_W'(2047));
    send_word(1'b0, CH_BS, 3'd3, IDX_W'(0));
    send_word(1'b0, 8'h41, 3'd0, IDX_W'(0));
    send_word(1'b0, 8'hFF, 3'd4, IDX_W'(2047));
    send_word(1'b0, 8'h00, 3'd7, IDX_W'(0));
    send_word(1'b0, 8'h80, 3'd5, IDX_W'(0));
    send_word(1'b0, CH_BS, 3'd1, IDX_W'(0));
    send_word(1'b0, CH_TAB, 3'd2, IDX_W'(0));
    send_word(1'b0, 8'h7E, 3'd6, IDX_W'(0));
    send_word(1'b0, CH_CR, 3'd0, IDX_W'(0));
    send_word(1'b0, CH_NL, 3'd0, IDX_W'(0));
    send_word(1'b0, CH_VT, 3'd0, IDX_W'(0));
    send_word(1'b0, CH_TAB, 3'd0, IDX_W'(0));
    send_word(1'b0, 8'h0C, 3'd2, IDX_W'(0));
    for (int i = 0; i < 4; i++) send_word(1'b1, 8'h00, 3'd0, IDX_W'(i));
    send_word(1'b1, 8'h00, 3'd0, IDX_W'(2*COLS + 4));
    drain_words();

    for (int ph = 0; ph < 3; ph++) begin
      pct = (ph == 0) ? 13 : (ph == 1) ? 58 : 0;
      for (int k = 0; k < 317; k++) begin
        send_random();
        if (k % 100 == 99) drain_words();
        else maybe_idle(pct);
      end
    end

    drain_words();
    repeat (12) @(posedge clk);
    $display("Sent %0d requests (%0d reads); %0d words checked, %0d screen scrolls.",
             n_sent, n_reads, words_seen, scrolls);
    $display("Idle mixes 13%%, 58%% and none, with drain pauses between bursts.");
    if (mismatches == 0 && words_pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #100_000_000;
    $display("Timeout: %0d words still outstanding", words_pending);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

/* filelist.f */
sv/tcw_pkg.sv
sv/tcw_ram.sv
sv/tcw_front.sv
sv/tcw_fifo.sv
sv/tcw_back.sv
sv/text_console_writer_core.sv
sim/tcw_checker.sv
sim/tb_text_console_writer_core.sv
